// ----- hw/rtl/upwind_advection_diffusion_cell_top_macros.svh -----
// assertion macros shared by the upwind advection-diffusion cell rtl
`ifndef UPWIND_ADVECTION_DIFFUSION_CELL_TOP_MACROS_SVH
`define UPWIND_ADVECTION_DIFFUSION_CELL_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define UDC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("udc assertion failed");

`define UDC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("udc assertion failed");

`else

`define UDC_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define UDC_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- hw/rtl/udc_pkg.sv -----
// types and constants of the upwind advection-diffusion cell
package udc_pkg;

    localparam int VAL_W    = 32;
    localparam int DIF_W    = 33;
    localparam int LAP_W    = 34;
    localparam int COEF_W   = 31;
    localparam int PRD_W    = 64;
    localparam int ACC_W    = 66;
    localparam int NUM_VALS = 9;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_ADV_X  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ADV_Y  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_VORT_X = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_VORT_Y = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TEMP_X = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TEMP_Y = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BUOY   = 3'd6;

    localparam logic CMD_VORT = 1'b0;
    localparam logic CMD_TEMP = 1'b1;

    typedef struct packed {
        logic [COEF_W-1:0] adv_x;
        logic [COEF_W-1:0] adv_y;
        logic [COEF_W-1:0] vort_x;
        logic [COEF_W-1:0] vort_y;
        logic [COEF_W-1:0] temp_x;
        logic [COEF_W-1:0] temp_y;
        logic [COEF_W-1:0] buoy;
    } cfg_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] c;
        logic signed [DIF_W-1:0] dxu;
        logic signed [DIF_W-1:0] dyu;
        logic signed [LAP_W-1:0] lapx;
        logic signed [LAP_W-1:0] lapy;
        logic signed [DIF_W-1:0] dtemp;
        logic [COEF_W-1:0]       kx;
        logic [COEF_W-1:0]       ky;
        logic [COEF_W-1:0]       kb;
        logic signed [PRD_W-1:0] px;
        logic signed [PRD_W-1:0] py;
    } prep_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] c;
        logic signed [64:0]      axh;
        logic signed [65:0]      axl;
        logic signed [64:0]      ayh;
        logic signed [65:0]      ayl;
        logic signed [65:0]      lx_p;
        logic signed [65:0]      ly_p;
        logic signed [64:0]      bz_p;
    } mul_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] ax;
        logic signed [ACC_W-1:0] ay;
        logic signed [ACC_W-1:0] base;
    } sum_t;

endpackage

// ----- hw/rtl/udc_prep.sv -----
// stage one: neighbor differences, laplacians, coefficient select, velocity products
`include "upwind_advection_diffusion_cell_top_macros.svh"

module udc_prep #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic                                       cmd,
    input  logic [udc_pkg::NUM_VALS*udc_pkg::VAL_W-1:0] vals,
    input  udc_pkg::cfg_t                              cfg,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output udc_pkg::prep_t                             out_data
);

    localparam int EW = (VALUE_WIDTH < udc_pkg::VAL_W) ? VALUE_WIDTH : udc_pkg::VAL_W;
    localparam int VW = udc_pkg::VAL_W;
    localparam int DW = udc_pkg::DIF_W;
    localparam int LW = udc_pkg::LAP_W;
    localparam int PW = udc_pkg::PRD_W;

    logic signed [VW-1:0] v [udc_pkg::NUM_VALS];
    logic signed [VW-1:0] c;
    logic signed [VW-1:0] w;
    logic signed [VW-1:0] e;
    logic signed [VW-1:0] s;
    logic signed [VW-1:0] n;
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic signed [VW-1:0] te;
    logic signed [VW-1:0] tw;
    logic                 temp_mode;
    udc_pkg::prep_t       data_next;
    udc_pkg::prep_t       data_reg;
    logic                 valid_next;
    logic                 valid_reg;

    always_comb
    begin
        for (int k = 0; k < udc_pkg::NUM_VALS; k++)
        begin
            v[k] = VW'($signed(vals[k*VW +: EW]));
        end
    end

    assign c  = v[0];
    assign w  = v[1];
    assign e  = v[2];
    assign s  = v[3];
    assign n  = v[4];
    assign vx = v[5];
    assign vy = v[6];
    assign te = v[7];
    assign tw = v[8];

    assign temp_mode = (cmd == udc_pkg::CMD_TEMP);

    always_comb
    begin
        data_next.c     = c;
        // upwind: backward difference for non-negative velocity
        data_next.dxu   = vx[VW-1] ? (DW'(e) - DW'(c)) : (DW'(c) - DW'(w));
        data_next.dyu   = vy[VW-1] ? (DW'(n) - DW'(c)) : (DW'(c) - DW'(s));
        data_next.lapx  = LW'(e) - (LW'(c) <<< 1) + LW'(w);
        data_next.lapy  = LW'(n) - (LW'(c) <<< 1) + LW'(s);
        data_next.dtemp = DW'(te) - DW'(tw);
        data_next.kx    = temp_mode ? cfg.temp_x : cfg.vort_x;
        data_next.ky    = temp_mode ? cfg.temp_y : cfg.vort_y;
        data_next.kb    = temp_mode ? '0 : cfg.buoy;
        data_next.px    = PW'($signed({1'b0, cfg.adv_x})) * PW'(vx);
        data_next.py    = PW'($signed({1'b0, cfg.adv_y})) * PW'(vy);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `UDC_ASSERT_NXT(a_temp_no_buoy, clk, rst_n,
        in_valid && in_ready && temp_mode, data_reg.kb == '0)

endmodule

// ----- hw/rtl/udc_mul.sv -----
// stage two: partial products of advection, diffusion and buoyancy terms
`include "upwind_advection_diffusion_cell_top_macros.svh"

module udc_mul (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  udc_pkg::prep_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output udc_pkg::mul_t  out_data
);

    localparam int HW = udc_pkg::PRD_W + 1;
    localparam int AW = udc_pkg::ACC_W;

    udc_pkg::mul_t data_next;
    udc_pkg::mul_t data_reg;
    logic          valid_next;
    logic          valid_reg;

    // velocity product split at bit 32 so each multiply stays near 32 x 32
    always_comb
    begin
        data_next.c    = in_data.c;
        data_next.axh  = HW'($signed(in_data.px[63:32])) * HW'(in_data.dxu);
        data_next.axl  = AW'($signed({1'b0, in_data.px[31:0]})) * AW'(in_data.dxu);
        data_next.ayh  = HW'($signed(in_data.py[63:32])) * HW'(in_data.dyu);
        data_next.ayl  = AW'($signed({1'b0, in_data.py[31:0]})) * AW'(in_data.dyu);
        data_next.lx_p = AW'($signed({1'b0, in_data.kx})) * AW'(in_data.lapx);
        data_next.ly_p = AW'($signed({1'b0, in_data.ky})) * AW'(in_data.lapy);
        data_next.bz_p = HW'($signed({1'b0, in_data.kb})) * HW'(in_data.dtemp);
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `UDC_ASSERT_NXT(a_zero_buoy_term, clk, rst_n,
        in_valid && in_ready && in_data.kb == '0, data_reg.bz_p == '0)

endmodule

// ----- hw/rtl/udc_sum.sv -----
// stage three: floor scaling of each term and the base partial sum (center plus diffusion minus buoyancy)
module udc_sum (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  udc_pkg::mul_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output udc_pkg::sum_t out_data
);

    localparam int AW = udc_pkg::ACC_W;

    logic signed [AW-1:0] lx;
    logic signed [AW-1:0] ly;
    logic signed [AW-1:0] bz;
    udc_pkg::sum_t        data_next;
    udc_pkg::sum_t        data_reg;
    logic                 valid_next;
    logic                 valid_reg;

    assign lx = in_data.lx_p >>> 16;
    assign ly = in_data.ly_p >>> 16;
    assign bz = AW'(in_data.bz_p) >>> 16;

    always_comb
    begin
        // floor of (hi * 2^32 + lo) / 2^32 is hi + floor(lo / 2^32)
        data_next.ax   = AW'(in_data.axh) + (in_data.axl >>> 32);
        data_next.ay   = AW'(in_data.ayh) + (in_data.ayl >>> 32);
        data_next.base = AW'(in_data.c) + lx + ly - bz;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hw/rtl/udc_sat.sv -----
// stages four and five: final sum, then saturation to the value range
`include "upwind_advection_diffusion_cell_top_macros.svh"

module udc_sat #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  udc_pkg::sum_t             in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [udc_pkg::VAL_W-1:0] out_val,
    output logic                      out_sat
);

    localparam int EW = (VALUE_WIDTH < udc_pkg::VAL_W) ? VALUE_WIDTH : udc_pkg::VAL_W;
    localparam int AW = udc_pkg::ACC_W;
    localparam int VW = udc_pkg::VAL_W;
    localparam logic signed [AW-1:0] HI_LIM = $signed((AW'(1) << (EW - 1)) - AW'(1));
    localparam logic signed [AW-1:0] LO_LIM = ~HI_LIM;

    logic signed [AW-1:0] acc_next;
    logic signed [AW-1:0] acc_reg;
    logic                 acc_valid_next;
    logic                 acc_valid_reg;
    logic                 acc_ready;
    logic [VW-1:0]        val_next;
    logic [VW-1:0]        val_reg;
    logic                 sat_next;
    logic                 sat_reg;
    logic                 out_valid_next;
    logic                 out_valid_reg;

    assign acc_next = in_data.base - in_data.ax - in_data.ay;

    always_comb
    begin
        priority if (acc_reg > HI_LIM)
        begin
            val_next = HI_LIM[VW-1:0];
            sat_next = 1'b1;
        end
        else if (acc_reg < LO_LIM)
        begin
            val_next = LO_LIM[VW-1:0];
            sat_next = 1'b1;
        end
        else
        begin
            val_next = acc_reg[VW-1:0];
            sat_next = 1'b0;
        end
    end

    assign acc_ready      = !out_valid_reg || out_ready;
    assign in_ready       = !acc_valid_reg || acc_ready;
    assign acc_valid_next = in_ready ? in_valid : acc_valid_reg;
    assign out_valid_next = acc_ready ? acc_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_valid_reg <= acc_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            acc_reg <= acc_next;
        end
        if (acc_valid_reg && acc_ready)
        begin
            val_reg <= val_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_val   = val_reg;
    assign out_sat   = sat_reg;

    `UDC_ASSERT_IMP(a_sat_at_bound, clk, rst_n, out_valid_reg && sat_reg, (val_reg == HI_LIM[VW-1:0]) || (val_reg == LO_LIM[VW-1:0]))

endmodule

// ----- hw/rtl/upwind_advection_diffusion_cell_top.sv -----
// top level of the upwind advection-diffusion cell update pipeline
//
// channel   direction  content
// s_axis    in         tuser cmd, tdata nine q16.16 values
// m_axis    out        tdata next_val, tuser saturated
// cfg       in         write enable, register index, 31-bit data
//
// one word per cycle sustained while the output is not stalled; a taken word passes through the five
// register stages in order (prep, multiply, scale, sum, saturate)
// each stage holds its word under backpressure and frees as soon as the next one moves
// reset clears the stage valid bits and all coefficient registers
`include "upwind_advection_diffusion_cell_top_macros.svh"

module upwind_advection_diffusion_cell_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            s_axis_tvalid,
    output logic                                            s_axis_tready,
    // center, west, east, south, north, vel_x, vel_y, temp_east, temp_west
    input  logic [udc_pkg::NUM_VALS*udc_pkg::VAL_W-1:0]     s_axis_tdata,
    // cmd
    input  logic                                            s_axis_tuser,
    output logic                                            m_axis_tvalid,
    input  logic                                            m_axis_tready,
    // next_val
    output logic [udc_pkg::VAL_W-1:0]                       m_axis_tdata,
    // saturated
    output logic                                            m_axis_tuser,
    input  logic                                            cfg_we,
    input  logic [udc_pkg::REG_IDX_W-1:0]                   cfg_addr,
    input  logic [udc_pkg::COEF_W-1:0]                      cfg_data
);

    udc_pkg::cfg_t  cfg_reg;
    udc_pkg::cfg_t  cfg_next;
    udc_pkg::prep_t prep_data;
    udc_pkg::mul_t  mul_data;
    udc_pkg::sum_t  sum_data;
    logic           prep_valid;
    logic           prep_ready;
    logic           mul_valid;
    logic           mul_ready;
    logic           sum_valid;
    logic           sum_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                udc_pkg::REG_ADV_X:  cfg_next.adv_x  = cfg_data;
                udc_pkg::REG_ADV_Y:  cfg_next.adv_y  = cfg_data;
                udc_pkg::REG_VORT_X: cfg_next.vort_x = cfg_data;
                udc_pkg::REG_VORT_Y: cfg_next.vort_y = cfg_data;
                udc_pkg::REG_TEMP_X: cfg_next.temp_x = cfg_data;
                udc_pkg::REG_TEMP_Y: cfg_next.temp_y = cfg_data;
                udc_pkg::REG_BUOY:   cfg_next.buoy   = cfg_data;
                default:             cfg_next        = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    udc_prep #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .cmd       (s_axis_tuser),
        .vals      (s_axis_tdata),
        .cfg       (cfg_reg),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    udc_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_data  (mul_data)
    );

    udc_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .in_data   (mul_data),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_data  (sum_data)
    );

    udc_sat #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_data   (sum_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_val   (m_axis_tdata),
        .out_sat   (m_axis_tuser)
    );

    `UDC_ASSERT_IMP(a_stall_only_when_full, clk, rst_n,
        !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the upwind advection-diffusion cell with bit-true predictor
module tb_top;

    localparam int IW = udc_pkg::REG_IDX_W;
    localparam int CW = udc_pkg::COEF_W;
    localparam logic [IW-1:0] REG_NONE = 3'd7;
    localparam int NUM_COEFS  = 7;
    localparam int LONG_HOLD  = 300;
    localparam int HOLD_AFTER = 600;
    localparam int IDLE_LIMIT = 3000;
    localparam int PHASE_LEN  = 250;

    typedef enum int {CF_ZERO, CF_SMALL, CF_MEDIUM, CF_FULL, CF_MAX, CF_MIXED} coef_mode_t;
    typedef enum int {RX_OPEN, RX_MOSTLY, RX_COIN, RX_TOGGLE} rx_pattern_t;

    typedef struct {
        logic               cmd;
        logic signed [31:0] center;
        logic signed [31:0] west;
        logic signed [31:0] east;
        logic signed [31:0] south;
        logic signed [31:0] north;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] temp_east;
        logic signed [31:0] temp_west;
    } cell_word_t;

    typedef struct {
        logic [31:0] next_val;
        logic        sat;
    } cell_result_t;

    logic                                          clk = 1'b0;
    logic                                          rst_n = 1'b0;
    logic                                          s_axis_tvalid = 1'b0;
    logic                                          s_axis_tready;
    logic [udc_pkg::NUM_VALS*udc_pkg::VAL_W-1:0]   s_axis_tdata = '0;
    logic                                          s_axis_tuser = 1'b0;
    logic                                          m_axis_tvalid;
    logic                                          m_axis_tready = 1'b0;
    logic [udc_pkg::VAL_W-1:0]                     m_axis_tdata;
    logic                                          m_axis_tuser;
    logic                                          cfg_we = 1'b0;
    logic [IW-1:0]                                 cfg_addr = '0;
    logic [CW-1:0]                                 cfg_data = '0;

    logic [CW-1:0]     coef_mirror [NUM_COEFS];
    cell_word_t        pending_cells [$];
    cell_result_t      expected_updates [$];
    cell_result_t      want;

    int          err_cnt = 0;
    int          words_out = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_cnt = 0;
    int          rx_tick = 0;
    bit          in_fire = 1'b0;
    bit          long_hold_done = 1'b0;
    rx_pattern_t rx_mode = RX_OPEN;

    upwind_advection_diffusion_cell_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic cell_result_t advance_cell(cell_word_t w);
        logic signed [127:0] c, wv, ev, sv, nv, vx, vy, te, tw;
        logic signed [127:0] kax, kay, kx, ky, kb, dxu, dyu, acc, lim_hi, lim_lo;
        cell_result_t r;
        c   = 128'(w.center);
        wv  = 128'(w.west);
        ev  = 128'(w.east);
        sv  = 128'(w.south);
        nv  = 128'(w.north);
        vx  = 128'(w.vel_x);
        vy  = 128'(w.vel_y);
        te  = 128'(w.temp_east);
        tw  = 128'(w.temp_west);
        kax = 128'(coef_mirror[udc_pkg::REG_ADV_X]);
        kay = 128'(coef_mirror[udc_pkg::REG_ADV_Y]);
        kb  = 128'(coef_mirror[udc_pkg::REG_BUOY]);
        kx  = (w.cmd == udc_pkg::CMD_TEMP) ? 128'(coef_mirror[udc_pkg::REG_TEMP_X])
                                           : 128'(coef_mirror[udc_pkg::REG_VORT_X]);
        ky  = (w.cmd == udc_pkg::CMD_TEMP) ? 128'(coef_mirror[udc_pkg::REG_TEMP_Y])
                                           : 128'(coef_mirror[udc_pkg::REG_VORT_Y]);
        // upwind: backward difference for non-negative velocity
        dxu = (vx >= 0) ? c - wv : ev - c;
        dyu = (vy >= 0) ? c - sv : nv - c;
        acc = c - ((kax * vx * dxu) >>> 32) - ((kay * vy * dyu) >>> 32)
                + ((kx * (ev - 2 * c + wv)) >>> 16) + ((ky * (nv - 2 * c + sv)) >>> 16);
        if (w.cmd == udc_pkg::CMD_VORT)
            acc = acc - ((kb * (te - tw)) >>> 16);
        lim_hi = 128'sh7fff_ffff;
        lim_lo = -lim_hi - 1;
        r.sat = 1'b1;
        if (acc > lim_hi)
            r.next_val = lim_hi[31:0];
        else if (acc < lim_lo)
            r.next_val = lim_lo[31:0];
        else
        begin
            r.next_val = acc[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic void queue_cell(logic cmd, logic [31:0] c, logic [31:0] w,
                                       logic [31:0] e, logic [31:0] s, logic [31:0] n,
                                       logic [31:0] vx, logic [31:0] vy,
                                       logic [31:0] te, logic [31:0] tw);
        cell_word_t item;
        item.cmd       = cmd;
        item.center    = c;
        item.west      = w;
        item.east      = e;
        item.south     = s;
        item.north     = n;
        item.vel_x     = vx;
        item.vel_y     = vy;
        item.temp_east = te;
        item.temp_west = tw;
        pending_cells.push_back(item);
    endfunction

    function automatic logic [31:0] pick_edge();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CW-1:0] pick_coef(coef_mode_t mode);
        coef_mode_t m;
        m = mode;
        if (m == CF_MIXED)
            m = coef_mode_t'($urandom_range(0, 4));
        case (m)
            CF_ZERO:   return '0;
            CF_SMALL:  return CW'($urandom_range(0, 65536));
            CF_MEDIUM: return CW'($urandom_range(0, 1 << 22));
            CF_MAX:    return '1;
            default:   return CW'($urandom);
        endcase
    endfunction

    task automatic write_coef(logic [IW-1:0] idx, logic [CW-1:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
        if (idx <= udc_pkg::REG_BUOY)
            coef_mirror[idx] = val;
    endtask

    task automatic load_coefs(coef_mode_t mode);
        int k;
        for (k = 0; k < NUM_COEFS; k++)
            write_coef(IW'(k), pick_coef(mode));
    endtask

    task automatic wait_drained();
        while (pending_cells.size() != 0 || expected_updates.size() != 0)
            @(negedge clk);
    endtask

    // sender: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && !in_fire)
            begin
            end
            else if (gap_left > 0)
            begin
                s_axis_tvalid <= 1'b0;
                gap_left      <= gap_left - 1;
            end
            else if (pending_cells.size() != 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_cells[0].cmd;
                s_axis_tdata  <= {pending_cells[0].temp_west, pending_cells[0].temp_east,
                                  pending_cells[0].vel_y, pending_cells[0].vel_x,
                                  pending_cells[0].north, pending_cells[0].south,
                                  pending_cells[0].east, pending_cells[0].west,
                                  pending_cells[0].center};
                if (burst_left > 1)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                              : $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver: periodically redrawn random stall pattern, plus one long hold-off
    always @(negedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (!long_hold_done && words_out >= HOLD_AFTER)
        begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= hold_cnt + 1;
            if (hold_cnt >= LONG_HOLD)
                long_hold_done <= 1'b1;
        end
        else
        begin
            if (rx_tick % 64 == 0)
                rx_mode <= rx_pattern_t'($urandom_range(0, 3));
            case (rx_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                default:   m_axis_tready <= rx_tick[2];
            endcase
        end
    end

    // scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                expected_updates.push_back(advance_cell(pending_cells.pop_front()));
            if (m_axis_tvalid && m_axis_tready)
            begin
                words_out <= words_out + 1;
                if (expected_updates.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected word, expected none, actual %h/%b",
                             $time, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = expected_updates.pop_front();
                    if (m_axis_tdata !== want.next_val)
                    begin
                        err_cnt++;
                        $display("%0t: next_val expected %h actual %h",
                                 $time, want.next_val, m_axis_tdata);
                    end
                    if (m_axis_tuser !== want.sat)
                    begin
                        err_cnt++;
                        $display("%0t: saturated expected %b actual %b",
                                 $time, want.sat, m_axis_tuser);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[upwind_advection_diffusion_cell_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        coef_mode_t  phase_modes [7];
        logic [31:0] f [9];
        int          base, kind, i, p, k;
        phase_modes = '{CF_SMALL, CF_MEDIUM, CF_SMALL, CF_MIXED, CF_FULL, CF_MAX, CF_MIXED};
        for (k = 0; k < NUM_COEFS; k++)
            coef_mirror[k] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // coefficients at reset value: the cell passes through
        queue_cell(udc_pkg::CMD_VORT, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
        queue_cell(udc_pkg::CMD_TEMP, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
        wait_drained();

        write_coef(udc_pkg::REG_ADV_X, 31'h0000_4000);
        write_coef(udc_pkg::REG_ADV_Y, 31'h0000_2000);
        write_coef(udc_pkg::REG_VORT_X, 31'h0000_1000);
        write_coef(udc_pkg::REG_VORT_Y, 31'h0000_0800);
        write_coef(udc_pkg::REG_TEMP_X, 31'h0000_0c00);
        write_coef(udc_pkg::REG_TEMP_Y, 31'h0000_0400);
        write_coef(udc_pkg::REG_BUOY, 31'h0000_8000);
        queue_cell(udc_pkg::CMD_VORT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_cell(udc_pkg::CMD_TEMP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_cell(udc_pkg::CMD_VORT, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 0, 0, 32'h8000_0000, 32'h8000_0000);
        queue_cell(udc_pkg::CMD_TEMP, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                   32'h7fff_ffff, 32'h7fff_ffff);
        queue_cell(udc_pkg::CMD_TEMP, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000,
                   32'h0000_4000, 32'h0003_0000, 0, 0, 0, 0);
        queue_cell(udc_pkg::CMD_TEMP, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000,
                   32'h0000_4000, 32'h0003_0000, 32'hffff_ffff, 32'hffff_ffff, 0, 0);
        queue_cell(udc_pkg::CMD_VORT, 32'hfffe_0000, 32'h0001_0000, 32'hffff_0000,
                   32'h0000_c000, 32'hfffd_0000, 32'h0000_0001, 32'hffff_ffff,
                   32'h0001_0000, 0);
        queue_cell(udc_pkg::CMD_VORT, 32'hfffe_0000, 32'h0001_0000, 32'hffff_0000,
                   32'h0000_c000, 32'hfffd_0000, 32'hffff_ffff, 32'h0000_0001,
                   0, 32'h0001_0000);
        queue_cell(udc_pkg::CMD_VORT, 32'h0000_1000, 0, 0, 0, 0, 0, 0,
                   32'h7fff_ffff, 32'h8000_0000);
        queue_cell(udc_pkg::CMD_TEMP, 32'h0000_1000, 0, 0, 0, 0, 0, 0,
                   32'h7fff_ffff, 32'h8000_0000);
        queue_cell(udc_pkg::CMD_VORT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'h7fff_ffff);
        queue_cell(udc_pkg::CMD_TEMP, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000);
        queue_cell(udc_pkg::CMD_VORT, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
        wait_drained();

        load_coefs(CF_MAX);
        for (i = 0; i < 8; i++)
            queue_cell(i[0], pick_edge(), pick_edge(), pick_edge(), pick_edge(), pick_edge(),
                       pick_edge(), pick_edge(), pick_edge(), pick_edge());
        wait_drained();

        for (p = 0; p < 7; p++)
        begin
            load_coefs(phase_modes[p]);
            if (phase_modes[p] == CF_MIXED)
                write_coef(REG_NONE, CW'($urandom));
            for (i = 0; i < PHASE_LEN; i++)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 5)
                begin
                    // smooth field with moderate velocities
                    base = int'($urandom_range(0, 1 << 22)) - (1 << 21);
                    for (k = 0; k < 5; k++)
                        f[k] = base + int'($urandom_range(0, 1 << 14)) - (1 << 13);
                    f[5] = int'($urandom_range(0, 1 << 18)) - (1 << 17);
                    f[6] = int'($urandom_range(0, 1 << 18)) - (1 << 17);
                    f[7] = int'($urandom_range(0, 1 << 19)) - (1 << 18);
                    f[8] = int'($urandom_range(0, 1 << 19)) - (1 << 18);
                end
                else if (kind < 8)
                begin
                    for (k = 0; k < 9; k++)
                        f[k] = $urandom;
                end
                else
                begin
                    for (k = 0; k < 9; k++)
                        f[k] = pick_edge();
                end
                queue_cell(1'($urandom_range(0, 1)), f[0], f[1], f[2], f[3], f[4],
                           f[5], f[6], f[7], f[8]);
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (err_cnt == 0)
            $display("[upwind_advection_diffusion_cell_top] OK");
        else
            $display("[upwind_advection_diffusion_cell_top] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/udc_pkg.sv
hw/rtl/udc_prep.sv
hw/rtl/udc_mul.sv
hw/rtl/udc_sum.sv
hw/rtl/udc_sat.sv
hw/rtl/upwind_advection_diffusion_cell_top.sv
verif/tb_top.sv
